FILE: rtl/line_token_splitter_unit_macros.svh
// ---------------------------------------------------------------------------
// line_token_splitter_unit_macros
// Assertion helpers for the line token splitter, clocked on aclk and
// disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef LINE_TOKEN_SPLITTER_UNIT_MACROS_SVH
`define LINE_TOKEN_SPLITTER_UNIT_MACROS_SVH

// same-cycle implication
`define LTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lts_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lts_pkg
// Types and constants shared by the line token splitter modules.
// ---------------------------------------------------------------------------
package lts_pkg;

    localparam logic [12:0] MAX_LINE   = 13'd4096;
    localparam logic [9:0]  MAX_TOKENS = 10'd512;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef enum logic [1:0] {
        KIND_TOKEN    = 2'd0,
        KIND_OK       = 2'd1,
        KIND_SYNTAX   = 2'd2,
        KIND_OVERFLOW = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [11:0] tok_begin;
        logic [12:0] tok_finish;
        logic [9:0]  count;
    } result_t;

    // results caused by one character, packed from slot 0
    typedef struct packed {
        logic                valid;
        logic [1:0]          cnt;
        result_t [2:0]       slot;
    } bundle_t;

endpackage

FILE: rtl/line_token_splitter_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_token_splitter_unit
// Splits a character stream into tokens and reports a status per line.
// ---------------------------------------------------------------------------
// The first result of a character is registered and appears on m_* in the cycle after acceptance.
// Throughput: one character per cycle; a character that yields k results
// (k up to 3) holds s_tready low until the result register has sent k-1.
// The rate is set by the single-result output register.
// Reset: aresetn low clears the line state and empties the result register.
`include "line_token_splitter_unit_macros.svh"

module line_token_splitter_unit
    import lts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // last_in_line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [11:0] tok_begin, [24:12] tok_finish, [34:25] count
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last
);

    bundle_t load;
    result_t res;
    logic    can_load;
    logic    accept;

    assign accept   = s_tvalid && can_load;
    assign s_tready = can_load;

    lts_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .ch      (s_tdata),
        .eol     (s_tlast),
        .load    (load)
    );

    lts_emitter u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .can_load  (can_load),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res),
        .out_last  (m_tlast)
    );

    assign m_tdata = {5'd0, res.count, res.tok_finish, res.tok_begin};
    assign m_tuser = res.kind;

    `LTS_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "idle but not ready")
    `LTS_ASSERT_NOW(a_status_is_last, m_tvalid && (m_tuser != KIND_TOKEN), m_tlast,
        "line status not final")
    `LTS_ASSERT_NOW(a_token_no_count, m_tvalid && (m_tuser == KIND_TOKEN),
        res.count == 10'd0, "token carries a count")
    `LTS_ASSERT_NOW(a_accept_while_busy, s_tvalid && s_tready && m_tvalid,
        m_tready && m_tlast, "accept while results pending")

endmodule

FILE: rtl/lts_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lts_core
// Per-line tokenizer state and the results one character produces.
// ---------------------------------------------------------------------------
module lts_core
    import lts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic [7:0]  ch,
    input  logic        eol,
    output bundle_t     load
);

    logic        in_token_reg,   in_token_next;
    logic [11:0] open_start_reg, open_start_next;
    logic [12:0] offset_reg,     offset_next;
    logic [9:0]  seen_reg,       seen_next;
    logic        done_reg,       done_next;
    logic        ovf_reg,        ovf_next;

    logic        active, white, delim, open_tok, close_tok;
    logic        close_ok, delim_tok, delim_ok;
    logic [9:0]  seen_a;
    result_t     r_close, r_delim, r_status;
    kind_t       status_kind;

    always_comb begin
        white = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
        delim = (ch == CH_DOT) || (ch == CH_COMMA) || (ch == CH_SEMI);
        active    = !done_reg && (offset_reg < MAX_LINE);
        open_tok  = active && !in_token_reg && !white;
        close_tok = active && in_token_reg && (white || delim);

        close_ok  = close_tok && (seen_reg < MAX_TOKENS);
        seen_a    = seen_reg + {9'd0, close_ok};
        delim_tok = close_tok && delim;
        delim_ok  = delim_tok && (seen_a < MAX_TOKENS);
        seen_next = seen_a + {9'd0, delim_ok};

        ovf_next  = ovf_reg || (close_tok && !close_ok) || (delim_tok && !delim_ok);
        done_next = done_reg || (close_tok && (ch == CH_SEMI));
        in_token_next   = open_tok ? 1'b1 : (close_tok ? 1'b0 : in_token_reg);
        open_start_next = open_tok ? offset_reg[11:0] : open_start_reg;
        offset_next     = active ? offset_reg + 13'd1 : offset_reg;

        if (ovf_next) begin
            status_kind = KIND_OVERFLOW;
        end else if (done_next) begin
            status_kind = KIND_OK;
        end else begin
            status_kind = KIND_SYNTAX;
        end

        r_close  = '{kind: KIND_TOKEN, tok_begin: open_start_reg,
                     tok_finish: offset_reg, count: 10'd0};
        r_delim  = '{kind: KIND_TOKEN, tok_begin: offset_reg[11:0],
                     tok_finish: offset_reg + 13'd1, count: 10'd0};
        r_status = '{kind: status_kind, tok_begin: 12'd0,
                     tok_finish: 13'd0, count: seen_next};

        // a delimiter token is only emitted after the closing token
        load.slot[0] = close_ok ? r_close : r_status;
        load.slot[1] = delim_ok ? r_delim : r_status;
        load.slot[2] = r_status;
        load.cnt     = {1'b0, close_ok} + {1'b0, delim_ok} + {1'b0, eol};
        load.valid   = accept && (load.cnt != 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_token_reg   <= 1'b0;
            open_start_reg <= 12'd0;
            offset_reg     <= 13'd0;
            seen_reg       <= 10'd0;
            done_reg       <= 1'b0;
            ovf_reg        <= 1'b0;
        end else if (accept) begin
            if (eol) begin
                in_token_reg   <= 1'b0;
                open_start_reg <= 12'd0;
                offset_reg     <= 13'd0;
                seen_reg       <= 10'd0;
                done_reg       <= 1'b0;
                ovf_reg        <= 1'b0;
            end else begin
                in_token_reg   <= in_token_next;
                open_start_reg <= open_start_next;
                offset_reg     <= offset_next;
                seen_reg       <= seen_next;
                done_reg       <= done_next;
                ovf_reg        <= ovf_next;
            end
        end
    end

endmodule

FILE: rtl/lts_emitter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lts_emitter
// Result register: holds the results of one character and hands them out
// one per transaction.
// ---------------------------------------------------------------------------
module lts_emitter
    import lts_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  bundle_t  load,
    output logic     can_load,
    output logic     out_valid,
    input  logic     out_ready,
    output result_t  out_res,
    output logic     out_last
);

    result_t [2:0] slot_reg;
    logic [1:0]    cnt_reg;
    logic [1:0]    idx_reg;
    logic          pop;

    always_comb begin
        out_valid = (cnt_reg != 2'd0);
        out_last  = (idx_reg == cnt_reg - 2'd1);
        pop       = out_valid && out_ready;
        can_load  = !out_valid || (out_ready && out_last);
        case (idx_reg)
            2'd0:    out_res = slot_reg[0];
            2'd1:    out_res = slot_reg[1];
            default: out_res = slot_reg[2];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else if (load.valid) begin
            cnt_reg <= load.cnt;
            idx_reg <= 2'd0;
        end else if (pop) begin
            if (out_last) begin
                cnt_reg <= 2'd0;
                idx_reg <= 2'd0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load.valid) begin
            slot_reg <= load.slot;
        end
    end

endmodule
